// ----- rtl/core/sdte_pkg.sv -----
// ----------------------------------------------------------------------------
// sdte_pkg
// Shared widths, character codes, types and the shift-add-3 step used by the
// signed decimal text emitter.
// ----------------------------------------------------------------------------
package sdte_pkg;

   localparam int VALUE_W         = 64;
   localparam int DIGITS          = 20;
   localparam int BCD_W           = 4 * DIGITS;
   localparam int CHAR_W          = 6;
   localparam int POS_W           = 5;
   localparam int STEPS_PER_STAGE = 8;
   localparam int DD_STAGES       = VALUE_W / STEPS_PER_STAGE;
   localparam int DD_W            = BCD_W + VALUE_W;

   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
   localparam logic [3:0]        DIG_FIVE = 4'd5;
   localparam logic [3:0]        DIG_ADJ  = 4'd3;

   // converted number handed from the pipeline to the character emitter
   typedef struct packed {
      logic [BCD_W-1:0] bcd;
      logic [POS_W-1:0] top;
      logic             neg;
   } digits_type;

   // one double-dabble step: adjust every digit of five or more, then shift
   function automatic logic [DD_W-1:0] dd_step(input logic [DD_W-1:0] s);
      logic [DD_W-1:0] t;
      t = s;
      for (int d = 0; d < DIGITS; d++) begin
         if (t[VALUE_W + 4*d +: 4] >= DIG_FIVE) begin
            t[VALUE_W + 4*d +: 4] = t[VALUE_W + 4*d +: 4] + DIG_ADJ;
         end
      end
      return {t[DD_W-2:0], 1'b0};
   endfunction

endpackage

// ----- rtl/core/sdte_req_if.sv -----
// ----------------------------------------------------------------------------
// sdte_req_if
// Input channel: one signed integer per transfer.
// ----------------------------------------------------------------------------
interface sdte_req_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/core/sdte_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sdte_rsp_if
// Result channel: one ASCII character per transfer, last marks end of number.
// ----------------------------------------------------------------------------
interface sdte_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- rtl/core/sdte_conv.sv -----
// ----------------------------------------------------------------------------
// sdte_conv
// Pipelined binary to BCD conversion: magnitude stage, eight double-dabble
// stages of eight bits each, and a leading-digit search stage.
// ----------------------------------------------------------------------------
module sdte_conv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [63:0]           in_value,
   output logic                  out_valid,
   output sdte_pkg::digits_type  out_digits
);
   import sdte_pkg::*;

   logic [DD_W-1:0]      dd_ff  [DD_STAGES+1];
   logic                 neg_ff [DD_STAGES+1];
   logic                 v_ff   [DD_STAGES+1];
   logic [DD_W-1:0]      dd_in  [DD_STAGES+1];
   logic                 neg_last;
   logic [POS_W-1:0]     top_in;
   digits_type           fin_ff;
   logic                 fin_v_ff;
   logic                 neg_in;
   logic [VALUE_W-1:0]   mag_in;

   // magnitude of the signed input
   always_comb begin
      neg_in = in_value[VALUE_W-1];
      mag_in = neg_in ? (~in_value + 64'd1) : in_value;
   end

   // stage zero input, then eight shift-add-3 steps per stage
   always_comb begin
      dd_in[0] = {{BCD_W{1'b0}}, mag_in};
      for (int k = 1; k <= DD_STAGES; k++) begin
         dd_in[k] = dd_ff[k-1];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            dd_in[k] = dd_step(dd_in[k]);
         end
      end
   end

   // highest nonzero digit, zero when the number is zero
   always_comb begin
      top_in = '0;
      for (int d = 0; d < DIGITS; d++) begin
         if (dd_ff[DD_STAGES][VALUE_W + 4*d +: 4] != 4'd0) begin
            top_in = POS_W'(d);
         end
      end
      neg_last = neg_ff[DD_STAGES];
   end

   // stage registers, all move together on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DD_STAGES; k++) begin
            v_ff[k] <= 1'b0;
         end
         fin_v_ff <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k <= DD_STAGES; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         fin_v_ff <= v_ff[DD_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dd_ff[0]  <= dd_in[0];
         neg_ff[0] <= neg_in;
         for (int k = 1; k <= DD_STAGES; k++) begin
            dd_ff[k]  <= dd_in[k];
            neg_ff[k] <= neg_ff[k-1];
         end
         fin_ff.bcd <= dd_ff[DD_STAGES][DD_W-1:VALUE_W];
         fin_ff.top <= top_in;
         fin_ff.neg <= neg_last;
      end
   end

   assign out_valid  = fin_v_ff;
   assign out_digits = fin_ff;

endmodule

// ----- rtl/core/signed_decimal_text_emitter_unit.sv -----
// ----------------------------------------------------------------------------
// signed_decimal_text_emitter_unit
// Renders signed 64-bit integers as decimal ASCII text, one character per
// result transfer, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one signed integer per transfer. rsp_chan returns its
//   text: a '-' for negative values, then the digits with leading zeros
//   suppressed (zero gives a single '0'); last is set on the final character.
//   The first character of a number passes the magnitude stage, eight
//   conversion stages, digit search, the emitter's load registers, then
//   the emitter's output register.
//   Throughput: one character per cycle while the receiver is ready, set by
//   the output register of the emitter. A number of n characters (1 to 20)
//   occupies the emitter until its last character is issued; the conversion
//   pipeline takes a new number every cycle while the emitter keeps up, and
//   the next number is loaded in the cycle its predecessor's last character is issued.
//   Reset clears all valid bits and the emitter; no clearing pass is needed.
//   When the receiver stalls, the held character stays and the emitter waits;
//   once a converted number waits on it, the whole pipeline freezes together and req_chan.ready drops.
// ----------------------------------------------------------------------------
module signed_decimal_text_emitter_unit (
   input  logic      clock,
   input  logic      reset,
   sdte_req_if.sink  req_chan,
   sdte_rsp_if.source rsp_chan
);
   import sdte_pkg::*;

   logic             conv_valid;
   digits_type       conv_digits;
   logic             advance;
   logic             take;
   logic             emit;
   logic             finishing;
   logic             out_free;

   logic             busy_ff,   busy_in;
   logic             neg_ff,    neg_in;
   logic [POS_W-1:0] pos_ff,    pos_in;
   logic [BCD_W-1:0] bcd_ff,    bcd_in;
   logic             rvalid_ff, rvalid_in;
   logic [CHAR_W-1:0] char_ff,  char_in;
   logic             last_ff,   last_in;

   sdte_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_chan.valid),
      .in_value   (req_chan.value),
      .out_valid  (conv_valid),
      .out_digits (conv_digits)
   );

   // emitter control
   always_comb begin
      out_free  = !rvalid_ff || rsp_chan.ready;
      emit      = busy_ff && out_free;
      finishing = !neg_ff && (pos_ff == '0);
      take      = conv_valid && (!busy_ff || (emit && finishing));
      advance   = !conv_valid || take;

      busy_in = busy_ff;
      neg_in  = neg_ff;
      pos_in  = pos_ff;
      bcd_in  = bcd_ff;
      if (take) begin
         busy_in = 1'b1;
         neg_in  = conv_digits.neg;
         pos_in  = conv_digits.top;
         bcd_in  = conv_digits.bcd;
      end else if (emit && finishing) begin
         busy_in = 1'b0;
      end else if (emit) begin
         if (neg_ff) begin
            neg_in = 1'b0;
         end else begin
            pos_in = pos_ff - 1'b1;
         end
      end

      rvalid_in = rvalid_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      if (emit) begin
         rvalid_in = 1'b1;
         char_in   = neg_ff ? CH_MINUS : (CH_ZERO + {2'b00, bcd_ff[4*pos_ff +: 4]});
         last_in   = finishing;
      end else if (rsp_chan.ready) begin
         rvalid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      pos_ff  <= pos_in;
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign req_chan.ready     = advance;
   assign rsp_chan.valid     = rvalid_ff;
   assign rsp_chan.char_code = char_ff;
   assign rsp_chan.last      = last_ff;

   // a minus sign never ends a run
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && (char_ff == CH_MINUS) |-> !last_ff)
      else $error("minus sign marked last");

   // only sign or digit codes leave the block
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> (char_ff == CH_MINUS) ||
                    ((char_ff >= CH_ZERO) && (char_ff <= CH_ZERO + 6'd9)))
      else $error("bad character code");

   // a new number is loaded only once the current one issues its last char
   a_load_when_done: assert property (@(posedge clock) disable iff (reset)
      take && busy_ff |-> emit && finishing)
      else $error("emitter overwritten mid run");

   // the pipeline never moves while its output waits on the emitter
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      conv_valid && !take |=> conv_valid && $stable(conv_digits))
      else $error("converted number lost");

endmodule
